// ----- rtl/core/hrp_pkg.sv -----
// Package for the hierarchical region profiler: widths, request kinds, status codes,
// controller-to-datapath command and status structures. No dependencies.
`timescale 1ns / 1ps

package hrp_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int TIME_BITS_DEF   = 48;
    localparam int REGION_BITS_DEF = 8;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CALLS_W  = 32;
    localparam int LEVEL_W  = 4;
    localparam int MIN_W    = 16;
    localparam int PCT_W    = 15;
    localparam int SAMP_W   = 16;
    localparam int OUT_REG_W = 8;

    localparam logic [PCT_W-1:0] FULL_PCT = 15'd25600;
    localparam logic [MIN_W-1:0] MIN_NONE = 16'hFFFF;

    localparam logic [KIND_W-1:0] K_OPEN  = 3'd0;
    localparam logic [KIND_W-1:0] K_CLOSE = 3'd1;
    localparam logic [KIND_W-1:0] K_REPORT = 3'd2;
    localparam logic [KIND_W-1:0] K_RST_REG = 3'd3;
    localparam logic [KIND_W-1:0] K_RST_ALL = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request
        logic exec;      // apply open, close or reset to the table
        logic rep_start; // clear walk index, latch span
        logic div_start; // start the percentage on current slot, by divider or directly
        logic avg_start; // start the average divider
        logic commit;    // write the slot statistics back and emit
        logic emit_one;  // emit the single non-report result
        logic emit_none; // emit the empty report result
        logic step;      // advance the walk index
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_report;
        logic cur_valid; // slot at walk index is valid
        logic walk_end;  // walk index at the last slot
        logic any_after; // a valid slot exists beyond the walk index
        logic div_done;
        logic out_busy;  // output register occupied and not being taken
    } t_sts;

endpackage

// ----- rtl/core/hrp_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module hrp_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem = w_trial - {1'b0, i_den};
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/core/hrp_datapath.sv -----
// Datapath of the region profiler: slot table, open stack, report walk,
// percentage and average dividers, output register. Depends on hrp_pkg and hrp_div.
`timescale 1ns / 1ps

module hrp_datapath #(
    parameter int NUM_SLOTS   = hrp_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS   = hrp_pkg::TIME_BITS_DEF,
    parameter int REGION_BITS = hrp_pkg::REGION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hrp_pkg::t_cmd               i_cmd,
    output hrp_pkg::t_sts               o_sts,
    input  logic [hrp_pkg::KIND_W-1:0]  i_kind,
    input  logic [REGION_BITS-1:0]      i_region_id,
    input  logic [TIME_BITS-1:0]        i_timestamp,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hrp_pkg::STATUS_W-1:0] o_status,
    output logic                        o_entry_valid,
    output logic [REGION_BITS-1:0]      o_slot_region,
    output logic [hrp_pkg::CALLS_W-1:0] o_call_count,
    output logic [hrp_pkg::LEVEL_W-1:0] o_nest_depth,
    output logic [hrp_pkg::MIN_W-1:0]   o_min_pct,
    output logic [hrp_pkg::PCT_W-1:0]   o_avg_pct,
    output logic [hrp_pkg::PCT_W-1:0]   o_max_pct,
    output logic                        o_last
);
    import hrp_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam int PNUM_W = TIME_BITS + PCT_W;
    localparam int ANUM_W = PCT_W + SAMP_W + 1;

    logic [NUM_SLOTS-1:0]   r_valid, r_open;
    logic [REGION_BITS-1:0] r_tag   [NUM_SLOTS];
    logic [CALLS_W-1:0]     r_calls [NUM_SLOTS];
    logic [LEVEL_W-1:0]     r_level [NUM_SLOTS];
    logic [TIME_BITS-1:0]   r_start [NUM_SLOTS];
    logic [TIME_BITS-1:0]   r_total [NUM_SLOTS];
    logic [TIME_BITS-1:0]   r_child [NUM_SLOTS];
    logic [PCT_W-1:0]       r_avg   [NUM_SLOTS];
    logic [MIN_W-1:0]       r_min   [NUM_SLOTS];
    logic [PCT_W-1:0]       r_max   [NUM_SLOTS];
    logic [SAMP_W-1:0]      r_samp  [NUM_SLOTS];
    logic [IDX_W-1:0]       r_stack [NUM_SLOTS];
    logic [CNT_W-1:0]       r_sp;
    logic [TIME_BITS-1:0]   r_root_begin, r_root_end, r_span;

    logic [KIND_W-1:0]      r_kind;
    logic [REGION_BITS-1:0] r_id;
    logic [TIME_BITS-1:0]   r_ts;
    logic [IDX_W-1:0]       r_idx;
    logic [PCT_W-1:0]       r_pct;
    logic                   r_phase; // 0 percentage divide, 1 average divide

    // Lookup of the request id and the first free slot.
    logic             w_found, w_free;
    logic [IDX_W-1:0] w_fidx, w_free_idx;
    always_comb begin
        w_found = 1'b0;
        w_free  = 1'b0;
        w_fidx  = '0;
        w_free_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!r_valid[i]) begin
                if (!w_free) begin
                    w_free = 1'b1;
                    w_free_idx = IDX_W'(i);
                end
            end else if (!w_found && r_tag[i] == r_id) begin
                w_found = 1'b1;
                w_fidx  = IDX_W'(i);
            end
        end
    end

    logic [NUM_SLOTS-1:0] w_after;
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++)
            w_after[i] = r_valid[i] && (IDX_W'(i) > r_idx);
    end

    // Self time and dividers.
    logic [TIME_BITS-1:0] w_self;
    assign w_self = (r_child[r_idx] >= r_total[r_idx]) ? '0 : r_total[r_idx] - r_child[r_idx];

    logic             w_pdone, w_adone;
    logic [PNUM_W-1:0] w_pquo;
    logic [ANUM_W-1:0] w_aquo;
    logic             w_pstart, w_astart;
    logic [ANUM_W-1:0] w_anum;
    logic [SAMP_W:0]   w_aden;
    logic [PCT_W-1:0]  w_pct_now;
    assign w_pstart = i_cmd.div_start && (r_span != '0) && (w_self < r_span);
    assign w_astart = i_cmd.avg_start;
    // The average divider starts in the cycle the percentage quotient appears.
    assign w_pct_now = w_pdone ? w_pquo[PCT_W-1:0] : r_pct;
    assign w_anum = ANUM_W'(r_avg[r_idx]) * ANUM_W'(r_samp[r_idx]) + ANUM_W'(w_pct_now);
    assign w_aden = {1'b0, r_samp[r_idx]} + 1'b1;

    hrp_div #(.NUM_W(PNUM_W), .DEN_W(TIME_BITS)) u_pdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_pstart),
        .i_num(PNUM_W'(w_self) * PNUM_W'(FULL_PCT)), .i_den(r_span),
        .o_done(w_pdone), .o_quo(w_pquo)
    );
    hrp_div #(.NUM_W(ANUM_W), .DEN_W(SAMP_W + 1)) u_adiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_astart),
        .i_num(w_anum), .i_den(w_aden), .o_done(w_adone), .o_quo(w_aquo)
    );

    // Percentage ready either from the divider or immediately.
    logic r_fast;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fast <= 1'b0;
        else r_fast <= i_cmd.div_start && !w_pstart;
        if (i_cmd.div_start) begin
            r_phase <= 1'b0;
            r_pct <= (r_span == '0) ? '0 : FULL_PCT;
        end else if (w_pdone) begin
            r_pct <= w_pquo[PCT_W-1:0];
        end
        if (i_cmd.avg_start) r_phase <= 1'b1;
    end

    logic w_out_take;
    assign w_out_take = o_valid && i_ready;

    assign o_sts.is_report = (r_kind == K_REPORT);
    assign o_sts.cur_valid = r_valid[r_idx];
    assign o_sts.walk_end  = (r_idx == IDX_W'(NUM_SLOTS - 1));
    assign o_sts.any_after = |w_after;
    assign o_sts.div_done  = r_phase ? w_adone : (w_pdone || r_fast);
    assign o_sts.out_busy  = o_valid && !i_ready;

    logic [STATUS_W-1:0] w_st;
    logic [IDX_W-1:0]    w_s, w_top, w_par;
    logic [TIME_BITS-1:0] w_el, w_tsum, w_csum;
    logic [TIME_BITS:0]  w_tadd, w_cadd;
    always_comb begin
        w_s   = w_found ? w_fidx : w_free_idx;
        w_top = r_stack[IDX_W'(r_sp - 1'b1)];
        w_par = r_stack[IDX_W'(r_sp - 2'd2)];
        w_el  = r_ts - r_start[w_top];
        w_tadd = {1'b0, r_total[w_top]} + {1'b0, w_el};
        w_tsum = w_tadd[TIME_BITS] ? TMAX : w_tadd[TIME_BITS-1:0];
        w_cadd = {1'b0, r_child[w_par]} + {1'b0, w_el};
        w_csum = w_cadd[TIME_BITS] ? TMAX : w_cadd[TIME_BITS-1:0];
        w_st = ST_OK;
        case (r_kind)
            K_OPEN: begin
                if (w_found && r_open[w_fidx]) w_st = ST_DOUBLE;
                else if (!w_found && !w_free) w_st = ST_FULL;
                else if (r_sp == CNT_W'(NUM_SLOTS)) w_st = ST_FULL;
            end
            K_CLOSE: if (r_sp == '0) w_st = ST_EMPTY;
            default: w_st = ST_OK;
        endcase
    end

    logic [PCT_W-1:0] w_navg;
    assign w_navg = w_aquo[PCT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_id   <= i_region_id;
            r_ts   <= i_timestamp;
        end
        if (i_cmd.rep_start) begin
            r_idx  <= '0;
            r_span <= r_root_end - r_root_begin;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_open  <= '0;
            r_sp    <= '0;
            r_root_begin <= '0;
            r_root_end   <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_tag[i] <= '0;  r_calls[i] <= '0; r_level[i] <= '0;
                r_total[i] <= '0; r_child[i] <= '0; r_avg[i] <= '0;
                r_min[i] <= MIN_NONE; r_max[i] <= '0; r_samp[i] <= '0;
            end
        end else begin
            if (w_out_take) o_valid <= 1'b0;
            if (i_cmd.exec && w_st == ST_OK) begin
                case (r_kind)
                    K_OPEN: begin
                        if (w_found) begin
                            if (r_calls[w_s] != '1) r_calls[w_s] <= r_calls[w_s] + 1'b1;
                        end else begin
                            r_valid[w_s] <= 1'b1;
                            r_tag[w_s]   <= r_id;
                            r_calls[w_s] <= CALLS_W'(1);
                            r_total[w_s] <= '0;
                            r_child[w_s] <= '0;
                        end
                        r_level[w_s] <= (r_sp > CNT_W'(15)) ? 4'd15 : LEVEL_W'(r_sp);
                        r_open[w_s]  <= 1'b1;
                        r_start[w_s] <= r_ts;
                        if (r_sp == '0) r_root_begin <= r_ts;
                        r_stack[IDX_W'(r_sp)] <= w_s;
                        r_sp <= r_sp + 1'b1;
                    end
                    K_CLOSE: begin
                        r_open[w_top] <= 1'b0;
                        if (r_sp > CNT_W'(1)) r_child[w_par] <= w_csum;
                        else r_root_end <= r_ts;
                        r_total[w_top] <= w_tsum;
                        r_sp <= r_sp - 1'b1;
                    end
                    K_RST_REG, K_RST_ALL: begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (r_kind == K_RST_ALL || r_tag[i] == r_id) begin
                                r_valid[i] <= 1'b0; r_samp[i] <= '0; r_avg[i] <= '0;
                                r_min[i] <= MIN_NONE; r_max[i] <= '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.emit_one || i_cmd.emit_none) begin
                o_valid <= 1'b1;
                o_status <= i_cmd.emit_one ? w_st : ST_OK;
                o_entry_valid <= 1'b0;
                o_slot_region <= '0; o_call_count <= '0; o_nest_depth <= '0;
                o_min_pct <= '0; o_avg_pct <= '0; o_max_pct <= '0;
                o_last <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_avg[r_idx] <= w_navg;
                if (r_samp[r_idx] != '1) r_samp[r_idx] <= r_samp[r_idx] + 1'b1;
                if (MIN_W'(r_pct) < r_min[r_idx]) r_min[r_idx] <= MIN_W'(r_pct);
                if (r_pct > r_max[r_idx]) r_max[r_idx] <= r_pct;
                r_calls[r_idx] <= '0; r_total[r_idx] <= '0; r_child[r_idx] <= '0;
                o_valid <= 1'b1;
                o_status <= ST_OK;
                o_entry_valid <= 1'b1;
                o_slot_region <= r_tag[r_idx];
                o_call_count <= r_calls[r_idx];
                o_nest_depth <= r_level[r_idx];
                o_min_pct <= (MIN_W'(r_pct) < r_min[r_idx]) ? MIN_W'(r_pct) : r_min[r_idx];
                o_avg_pct <= w_navg;
                o_max_pct <= (r_pct > r_max[r_idx]) ? r_pct : r_max[r_idx];
                o_last <= !(|w_after);
            end
        end
    end

endmodule

// ----- rtl/core/hrp_ctrl.sv -----
// Controller of the region profiler: sequences request capture, table update
// and the report walk. Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hrp_pkg::t_sts i_sts,
    output hrp_pkg::t_cmd o_cmd
);
    import hrp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_PDIV = 7'b0001000,
        S_ADIV = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_NONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_seen, n_seen;

    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_sts.out_busy;
                if (i_in_valid && !i_sts.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_report) begin
                    o_cmd.rep_start = 1'b1;
                    n_seen  = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.exec = 1'b1;
                    o_cmd.emit_one = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.cur_valid) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_PDIV;
                end else if (i_sts.walk_end) begin
                    n_state = r_seen ? S_IDLE : S_NONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_PDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.avg_start = 1'b1;
                    n_state = S_ADIV;
                end
            end
            S_ADIV: if (i_sts.div_done) n_state = S_EMIT;
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_seen = 1'b1;
                    if (i_sts.walk_end || !i_sts.any_after) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_NONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit_none = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
        end
    end

endmodule

// ----- rtl/core/hierarchical_region_profiler_unit.sv -----
// Top level of the hierarchical region profiler: stream ports, controller and datapath.
// Depends on hrp_pkg, hrp_ctrl and hrp_datapath.
`timescale 1ns / 1ps

// The profiler takes one request at a time. Open, close, reset-region and
// reset-all requests, and undecoded kinds, are captured and then executed, each
// giving a single result. A report walks the slot table, stepping over empty
// slots at one slot per cycle and ending after the last valid slot; each valid
// slot goes through the percentage divider (not started when the span is zero or
// the self time covers the whole span) and the average divider, both one bit a
// cycle, and is then emitted. A report with no valid slot gives one empty result.
// A stalled result holds the walk until the output register is free again.
// A new request is taken only once the previous result has left the output
// register or is being taken.
module hierarchical_region_profiler_unit #(
    parameter int NUM_SLOTS   = hrp_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS   = hrp_pkg::TIME_BITS_DEF,
    parameter int REGION_BITS = hrp_pkg::REGION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata fields from bit 0: region_id, timestamp (zero padded to bytes)
    input  logic [((REGION_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: kind
    input  logic [hrp_pkg::KIND_W-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata fields from bit 0: entry_valid, slot_region, call_count, nest_depth,
    // min_pct, avg_pct, max_pct (zero padded to bytes)
    output logic [((1 + REGION_BITS + 32 + 4 + 16 + 15 + 15 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: status
    output logic [hrp_pkg::STATUS_W-1:0] m_axis_tuser,
    output logic m_axis_tlast
);
    import hrp_pkg::*;

    localparam int OW = 1 + REGION_BITS + CALLS_W + LEVEL_W + MIN_W + 2 * PCT_W;
    localparam int OWP = ((OW + 7) / 8) * 8;

    t_cmd w_cmd;
    t_sts w_sts;

    logic                   w_ev;
    logic [REGION_BITS-1:0] w_reg;
    logic [CALLS_W-1:0]     w_calls;
    logic [LEVEL_W-1:0]     w_lvl;
    logic [MIN_W-1:0]       w_min;
    logic [PCT_W-1:0]       w_avg, w_max;

    hrp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    hrp_datapath #(
        .NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS), .REGION_BITS(REGION_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_kind(s_axis_tuser),
        .i_region_id(s_axis_tdata[REGION_BITS-1:0]),
        .i_timestamp(s_axis_tdata[REGION_BITS +: TIME_BITS]),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(m_axis_tuser), .o_entry_valid(w_ev), .o_slot_region(w_reg),
        .o_call_count(w_calls), .o_nest_depth(w_lvl), .o_min_pct(w_min),
        .o_avg_pct(w_avg), .o_max_pct(w_max), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = OWP'({w_max, w_avg, w_min, w_lvl, w_calls, w_reg, w_ev});

`ifndef SYNTHESIS
    // No request is taken while a result waits unconsumed.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted while result stalled");
    // An error status never carries slot data.
    a_status_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (!w_ev && m_axis_tlast))
        else $error("error status on a report entry");
    // A non-report request is answered once it has passed the request and output registers.
    a_quick_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != K_REPORT) |=> ##1 m_axis_tvalid)
        else $error("missing single result");
`endif

endmodule

// ----- bench/hrp_profile_checker.sv -----
// Checker for the hierarchical region profiler: watches both stream channels, keeps its own
// copy of the slot table and stack, and compares every result with its prediction.
// Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_profile_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [55:0] i_req_data,
    input  logic [2:0]  i_req_kind,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [95:0] i_res_data,
    input  logic [1:0]  i_res_status,
    input  logic        i_res_last,
    output int          o_failures,
    output int          o_pending,
    output int          o_results
);
    import hrp_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [47:0] TIME_MAX = '1;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_valid;
        logic [7:0]  region;
        logic [31:0] calls;
        logic [3:0]  depth;
        logic [15:0] min_pct;
        logic [14:0] avg_pct;
        logic [14:0] max_pct;
        logic        last;
    } t_result;

    t_result expected_results[$];

    logic        slot_valid[SLOTS];
    logic [7:0]  slot_tag[SLOTS];
    logic        slot_open[SLOTS];
    logic [31:0] slot_calls[SLOTS];
    logic [3:0]  slot_level[SLOTS];
    logic [47:0] slot_start[SLOTS];
    logic [47:0] slot_total[SLOTS];
    logic [47:0] slot_child[SLOTS];
    logic [14:0] slot_avg[SLOTS];
    logic [15:0] slot_min[SLOTS];
    logic [14:0] slot_max[SLOTS];
    logic [15:0] slot_samples[SLOTS];
    logic [3:0]  open_stack[SLOTS];
    logic [4:0]  stack_count;
    logic [47:0] root_begin;
    logic [47:0] root_end;

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? TIME_MAX : s[47:0];
    endfunction

    task automatic forget_stats(int i);
        slot_valid[i]   = 1'b0;
        slot_samples[i] = '0;
        slot_avg[i]     = '0;
        slot_min[i]     = MIN_NONE;
        slot_max[i]     = '0;
    endtask

    task automatic clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            forget_stats(i);
            slot_tag[i] = '0; slot_open[i] = 1'b0; slot_calls[i] = '0;
            slot_level[i] = '0; slot_start[i] = '0; slot_total[i] = '0;
            slot_child[i] = '0; open_stack[i] = '0;
        end
        stack_count = '0; root_begin = '0; root_end = '0;
    endtask

    function automatic t_result plain_result(logic [1:0] st);
        t_result r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [1:0] open_region(logic [7:0] id, logic [47:0] ts);
        int found, vacant, s;
        found = -1; vacant = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_valid[i]) begin
                if (vacant < 0) vacant = i;
            end else if (found < 0 && slot_tag[i] == id) begin
                found = i;
            end
        end
        if (found >= 0 && slot_open[found]) return ST_DOUBLE;
        if (found < 0 && vacant < 0) return ST_FULL;
        if (stack_count >= SLOTS) return ST_FULL;
        if (found >= 0) begin
            s = found;
            if (slot_calls[s] != '1) slot_calls[s]++;
        end else begin
            s = vacant;
            slot_valid[s] = 1'b1; slot_tag[s] = id; slot_calls[s] = 1;
            slot_total[s] = '0; slot_child[s] = '0;
        end
        slot_level[s] = stack_count > 15 ? 4'd15 : stack_count[3:0];
        slot_open[s]  = 1'b1;
        slot_start[s] = ts;
        if (stack_count == 0) root_begin = ts;
        open_stack[stack_count[3:0]] = s[3:0];
        stack_count++;
        return ST_OK;
    endfunction

    function automatic logic [1:0] close_region(logic [47:0] ts);
        int s, p;
        logic [47:0] elapsed;
        if (stack_count == 0) return ST_EMPTY;
        s = open_stack[stack_count - 1];
        elapsed = ts - slot_start[s];
        slot_open[s] = 1'b0;
        if (stack_count > 1) begin
            p = open_stack[stack_count - 2];
            slot_child[p] = add_sat(slot_child[p], elapsed);
        end else begin
            root_end = ts;
        end
        slot_total[s] = add_sat(slot_total[s], elapsed);
        stack_count--;
        return ST_OK;
    endfunction

    task automatic report_frame();
        logic [47:0] span, self_time;
        logic [14:0] pct;
        logic [63:0] q;
        int emitted;
        t_result r;
        emitted = 0;
        span = root_end - root_begin;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i]) begin
                self_time = slot_child[i] >= slot_total[i] ? 48'd0
                                                           : slot_total[i] - slot_child[i];
                if (span == 0) pct = '0;
                else if (self_time >= span) pct = FULL_PCT;
                else begin
                    q = (64'(self_time) * 64'(FULL_PCT)) / 64'(span);
                    pct = q[14:0];
                end
                q = (64'(slot_avg[i]) * 64'(slot_samples[i]) + 64'(pct))
                    / (64'(slot_samples[i]) + 64'd1);
                slot_avg[i] = q[14:0];
                if (slot_samples[i] != '1) slot_samples[i]++;
                if (pct < slot_min[i]) slot_min[i] = {1'b0, pct};
                if (pct > slot_max[i]) slot_max[i] = pct;
                r = '0;
                r.status = ST_OK; r.entry_valid = 1'b1; r.region = slot_tag[i];
                r.calls = slot_calls[i]; r.depth = slot_level[i];
                r.min_pct = slot_min[i]; r.avg_pct = slot_avg[i]; r.max_pct = slot_max[i];
                expected_results.push_back(r);
                emitted++;
                slot_calls[i] = '0; slot_total[i] = '0; slot_child[i] = '0;
            end
        end
        if (emitted == 0) expected_results.push_back(plain_result(ST_OK));
        else expected_results[$].last = 1'b1;
    endtask

    task automatic apply_request(logic [2:0] kind, logic [7:0] id, logic [47:0] ts);
        logic [1:0] st;
        st = ST_OK;
        case (kind)
            K_OPEN:    st = open_region(id, ts);
            K_CLOSE:   st = close_region(ts);
            K_REPORT:  report_frame();
            K_RST_REG: begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_tag[i] == id) forget_stats(i);
            end
            K_RST_ALL: begin
                for (int i = 0; i < SLOTS; i++) forget_stats(i);
            end
            default: ;
        endcase
        if (kind != K_REPORT) expected_results.push_back(plain_result(st));
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        o_failures++;
    endtask

    task automatic compare_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $display("[%0t] result arrived with nothing outstanding", $realtime);
            o_failures++;
            return;
        end
        want = expected_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.entry_valid != want.entry_valid)
            report_mismatch("entry_valid", got.entry_valid, want.entry_valid);
        if (got.region != want.region) report_mismatch("slot_region", got.region, want.region);
        if (got.calls != want.calls) report_mismatch("call_count", got.calls, want.calls);
        if (got.depth != want.depth) report_mismatch("nest_depth", got.depth, want.depth);
        if (got.min_pct != want.min_pct) report_mismatch("min_pct", got.min_pct, want.min_pct);
        if (got.avg_pct != want.avg_pct) report_mismatch("avg_pct", got.avg_pct, want.avg_pct);
        if (got.max_pct != want.max_pct) report_mismatch("max_pct", got.max_pct, want.max_pct);
        if (got.last != want.last) report_mismatch("last", got.last, want.last);
    endtask

    initial begin
        o_failures = 0;
        o_results  = 0;
        clear_table();
    end

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            clear_table();
            expected_results.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                apply_request(i_req_kind, i_req_data[7:0], i_req_data[55:8]);
            if (i_res_valid && i_res_ready) begin
                got.status      = i_res_status;
                got.entry_valid = i_res_data[0];
                got.region      = i_res_data[8:1];
                got.calls       = i_res_data[40:9];
                got.depth       = i_res_data[44:41];
                got.min_pct     = i_res_data[60:45];
                got.avg_pct     = i_res_data[75:61];
                got.max_pct     = i_res_data[90:76];
                got.last        = i_res_last;
                compare_result(got);
                o_results++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- bench/tb.sv -----
// Top of the profiler testbench: clock, reset, request stimulus and result back-pressure.
// Depends on hrp_pkg, hrp_profile_checker and hierarchical_region_profiler_unit.
`timescale 1ns / 1ps

module tb;
    import hrp_pkg::*;

    // Kinds above reset-all are not decoded; the block must answer them with a plain OK.
    localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_LAST  = 3'd7;
    localparam logic [47:0] TS_MAX = '1;
    localparam int TARGET_REQUESTS = 400;
    // The limit leaves a wide margin even with every request a report and long stalls
    // on the result side.
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid, s_ready;
    logic [55:0] s_data;   // region_id [7:0], timestamp [55:8]
    logic [2:0]  s_kind;   // kind
    logic        m_valid, m_ready, m_last;
    logic [95:0] m_data;   // entry_valid, slot_region, call_count, nest_depth, min, avg, max
    logic [1:0]  m_status; // status

    int     failures, pending, results;
    int     sent;
    longint cycles;
    logic [47:0] now_ts;
    logic        stall_free;

    hierarchical_region_profiler_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_kind),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_status),
        .m_axis_tlast  (m_last)
    );

    hrp_profile_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_valid),
        .i_req_ready  (s_ready),
        .i_req_data   (s_data),
        .i_req_kind   (s_kind),
        .i_res_valid  (m_valid),
        .i_res_ready  (m_ready),
        .i_res_data   (m_data),
        .i_res_status (m_status),
        .i_res_last   (m_last),
        .o_failures   (failures),
        .o_pending    (pending),
        .o_results    (results)
    );

    // The clock starts low so that no rising edge falls at time zero.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Mostly short gaps, now and then a long one; in stall-free stretches none at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (stall_free || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result-side back-pressure, changed once per clock edge.
    int hold_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready     <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_cycles > 0) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready     <= 1'b1;
            hold_cycles <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // One request: present it at a clock edge, hold it until taken, then maybe idle.
    task automatic send_request(logic [2:0] kind, logic [7:0] id, logic [47:0] ts);
        int gap;
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= {ts, id};
        do @(posedge i_clk); while (!s_ready);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_region();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 21));
    endfunction

    function automatic logic [47:0] random_ts();
        return {16'($urandom), $urandom};
    endfunction

    // A well-formed frame: nested opens and closes with rising times, a full unwind,
    // and usually a report. A few requests in a frame are noise.
    task automatic run_frame();
        int depth, steps;
        logic [2:0] noise_kind;
        depth = 0;
        steps = $urandom_range(2, 24);
        now_ts = $urandom_range(0, 3) == 0 ? random_ts() : now_ts + $urandom_range(1, 50);
        send_request(K_OPEN, pick_region(), now_ts);
        depth++;
        for (int k = 0; k < steps; k++) begin
            now_ts = now_ts + $urandom_range(0, 400);
            if ($urandom_range(0, 19) == 0) begin
                noise_kind = 3'($urandom_range(0, 7));
                send_request(noise_kind, pick_region(), random_ts());
                if (noise_kind == K_OPEN) depth++;
                if (noise_kind == K_CLOSE && depth > 0) depth--;
            end else if (depth == 0 || (depth < 18 && $urandom_range(0, 1) == 0)) begin
                send_request(K_OPEN, pick_region(), now_ts);
                depth++;
            end else begin
                send_request(K_CLOSE, pick_region(), now_ts);
                depth--;
            end
        end
        // Extra closes beyond the stack simply return the empty status.
        repeat (depth + $urandom_range(0, 1)) begin
            now_ts = now_ts + $urandom_range(0, 400);
            send_request(K_CLOSE, pick_region(), now_ts);
        end
        if ($urandom_range(0, 9) < 7) send_request(K_REPORT, pick_region(), random_ts());
        if ($urandom_range(0, 9) == 0) send_request(K_RST_REG, pick_region(), random_ts());
        if ($urandom_range(0, 19) == 0) send_request(K_RST_ALL, pick_region(), random_ts());
    endtask

    initial begin
        i_rst_n    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = '0;
        s_data     = '0;
        m_ready    = 1'b0;
        cycles     = 0;
        sent       = 0;
        now_ts     = '0;
        stall_free = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty close, empty report, spare kinds.
        send_request(K_CLOSE, 8'd0, 48'd0);
        send_request(K_REPORT, 8'd0, 48'd0);
        for (int k = K_SPARE_FIRST; k <= K_SPARE_LAST; k++)
            send_request(3'(k), 8'hFF, TS_MAX);
        // Root at the top of the time range, child opened twice (second is a double open),
        // then closes that wrap around zero.
        send_request(K_OPEN, 8'd0, TS_MAX - 48'd100);
        send_request(K_OPEN, 8'hFF, TS_MAX - 48'd50);
        send_request(K_OPEN, 8'hFF, TS_MAX - 48'd40);
        send_request(K_CLOSE, 8'd0, 48'd20);
        send_request(K_CLOSE, 8'd0, 48'd400);
        send_request(K_REPORT, 8'd0, 48'd0);
        // Elapsed times of almost the full range twice over saturate the total.
        send_request(K_OPEN, 8'd0, 48'd1);
        send_request(K_CLOSE, 8'd0, 48'd0);
        send_request(K_OPEN, 8'd0, 48'd1);
        send_request(K_CLOSE, 8'd0, 48'd0);
        send_request(K_REPORT, 8'd0, 48'd0);
        // Zero span: open and close at the same time.
        send_request(K_OPEN, 8'h55, 48'hAAAA_AAAA_AAAA);
        send_request(K_CLOSE, 8'h55, 48'hAAAA_AAAA_AAAA);
        send_request(K_REPORT, 8'h55, 48'd0);
        send_request(K_RST_REG, 8'hFF, 48'd0);
        send_request(K_RST_ALL, 8'd0, 48'd0);
        wait_drained();

        // Table full: sixteen nested opens fill table and stack, the seventeenth fails.
        for (int k = 0; k < 17; k++) send_request(K_OPEN, 8'(k * 13), 48'(1000 + k));
        for (int k = 0; k < 16; k++) send_request(K_CLOSE, 8'd0, 48'(5000 + k * 7));
        send_request(K_REPORT, 8'd0, 48'd0);
        wait_drained();

        while (sent < TARGET_REQUESTS) begin
            stall_free = $urandom_range(0, 4) == 0;
            run_frame();
            // Now and then hold off until the block has caught up entirely.
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        stall_free = 1'b0;
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("%0d requests sent in nested frames with reports, resets and stray kinds;",
                 sent);
        $display("%0d results compared over %0d cycles", results, cycles);
        if (failures == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- hierarchical_region_profiler_unit.f -----
rtl/core/hrp_pkg.sv
rtl/core/hrp_div.sv
rtl/core/hrp_datapath.sv
rtl/core/hrp_ctrl.sv
rtl/core/hierarchical_region_profiler_unit.sv
bench/hrp_profile_checker.sv
bench/tb.sv
